### hw/rtl/shs_pkg.sv
// ---------------------------------------------------------------------------
// shs_pkg: shared types and constants for the sample histogram block
// Holds command and status codes, and the controller-to-datapath command set.
// ---------------------------------------------------------------------------
package shs_pkg;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_PDF     = 3'd1,
        CMD_CDF     = 3'd2,
        CMD_SUMMARY = 3'd3,
        CMD_CLEAR   = 3'd4
    } command_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_UNDEFINED = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LATCH     = 4'd1,   // capture request, reset scan
        OP_SCAN      = 4'd2,   // process one table entry
        OP_COMMIT    = 4'd3,   // apply add
        OP_CLEAR     = 4'd4,
        OP_DIV_INIT  = 4'd5,   // load divider operands
        OP_DIV_STEP  = 4'd6,
        OP_MUL_STEP  = 4'd7,   // one partial product of the variance terms
        OP_SQRT_INIT = 4'd8,
        OP_SQRT_STEP = 4'd9,
        OP_RESULT    = 4'd10
    } op_t;

    // Which division is in progress.
    typedef enum logic [1:0] {
        DIV_PROB = 2'd0,
        DIV_MEAN = 2'd1,
        DIV_VAR  = 2'd2
    } div_sel_t;

    typedef struct packed {
        op_t      op;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;   // scan reached end or found entry
        logic div_done;
        logic mul_done;
        logic sqrt_done;
        logic empty;       // no samples held
        logic too_few;     // summary undefined in current mode
    } dp_status_t;

endpackage

### hw/rtl/sample_histogram_statistics.sv
// ---------------------------------------------------------------------------
// sample_histogram_statistics: value histogram with running mean and sigma
// Top level: joins the sequencer, the datapath and the mode register.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, command, value) takes one request at
//   a time: add sample, pdf, cdf, summary or clear. Each request returns one
//   result on the output channel (out_valid / out_stall).
//   Add scans the held table at one entry a cycle and stops early when the
//   value is found; pdf and cdf scan the whole table, then, unless it is
//   empty, run an 80-step divide. Summary runs two 80-step bit-serial
//   divides, four 16-bit partial products and a 40-step root. Clear, unused
//   commands and an undefined summary skip the scan and the arithmetic.
//   One request is in flight at a time; in_stall is high until its result
//   has been taken, and the next request can be accepted in the cycle after.
//   Reset empties the table and sets population mode. A receiver stall holds
//   the result and the block. population_mode is written through cfg_valid /
//   cfg_ready, which is ready only while no request is in flight.
// ---------------------------------------------------------------------------
module sample_histogram_statistics #(
    parameter int TABLE_DEPTH  = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     command,
    input  logic signed [SAMPLE_WIDTH-1:0] value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [COUNT_WIDTH-1:0]         match_count,
    output logic [COUNT_WIDTH-1:0]         total_count,
    output logic [16:0]                    probability,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] distinct_count,
    output logic signed [SAMPLE_WIDTH-1:0] lowest,
    output logic signed [SAMPLE_WIDTH-1:0] highest,
    output logic signed [SAMPLE_WIDTH-1:0] mean,
    output logic [SAMPLE_WIDTH-1:0]        sigma,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);
    import shs_pkg::*;

    dp_cmd_t    dcmd;
    dp_status_t dstat;
    logic       population_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            population_mode_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            population_mode_reg <= cfg_data;
    end

    shs_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_command (command),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cfg_ready  (cfg_ready),
        .cmd        (dcmd),
        .stat       (dstat)
    );

    shs_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dcmd),
        .stat            (dstat),
        .population_mode (population_mode_reg),
        .in_command      (command),
        .in_value        (value),
        .res_status      (status),
        .res_match       (match_count),
        .res_total       (total_count),
        .res_prob        (probability),
        .res_distinct    (distinct_count),
        .res_lowest      (lowest),
        .res_highest     (highest),
        .res_mean        (mean),
        .res_sigma       (sigma)
    );
endmodule

### hw/rtl/shs_datapath.sv
// ---------------------------------------------------------------------------
// shs_datapath: table memory, running totals and shared arithmetic units
// Scans the table one entry a cycle; divides and takes roots bit-serially.
// ---------------------------------------------------------------------------
module shs_datapath #(
    parameter int TABLE_DEPTH  = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shs_pkg::dp_cmd_t              cmd,
    output shs_pkg::dp_status_t           stat,
    input  logic                          population_mode,
    input  logic [2:0]                    in_command,
    input  logic signed [SAMPLE_WIDTH-1:0] in_value,
    output logic [1:0]                    res_status,
    output logic [COUNT_WIDTH-1:0]        res_match,
    output logic [COUNT_WIDTH-1:0]        res_total,
    output logic [16:0]                   res_prob,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] res_distinct,
    output logic signed [SAMPLE_WIDTH-1:0] res_lowest,
    output logic signed [SAMPLE_WIDTH-1:0] res_highest,
    output logic signed [SAMPLE_WIDTH-1:0] res_mean,
    output logic [SAMPLE_WIDTH-1:0]       res_sigma
);
    import shs_pkg::*;

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int DW  = $clog2(TABLE_DEPTH + 1);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = COUNT_WIDTH;
    localparam int SUMW = SW + CW;                // running sum
    localparam int SQW  = 2 * SW + CW;            // sum of squares
    localparam int VW   = CW + SQW;               // n*sumsq, and sum^2 fits too
    localparam int DIVW = 2 * CW;                 // divisor n*n
    localparam int NUMW = (VW > CW + 17) ? VW : CW + 17;
    localparam int NBW  = $clog2(NUMW + 1);
    localparam int RW   = (VW + 1) / 2;           // root width
    localparam int SQSTEPS = RW;
    localparam int MULW = 16;                     // partial product slice
    localparam int MSLICES = (SQW + MULW - 1) / MULW;
    localparam int MSW = $clog2(MSLICES + 1);
    localparam logic signed [SW-1:0] SMAXV = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMINV = {1'b1, {(SW-1){1'b0}}};

    // table memories
    logic signed [SW-1:0] value_mem [TABLE_DEPTH];
    logic [CW-1:0]        count_mem [TABLE_DEPTH];
    logic signed [SW-1:0] rd_value;
    logic [CW-1:0]        rd_count;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic signed [SW-1:0] wr_value;
    logic [CW-1:0]        wr_count;

    // totals
    logic [DW-1:0]        distinct_reg;
    logic [CW-1:0]        total_reg;
    logic [SUMW-1:0]      sum_reg;
    logic [SQW-1:0]       sqsum_reg;
    logic signed [SW-1:0] low_reg, high_reg;

    // request and scan
    logic [2:0]           rcmd_reg;
    logic signed [SW-1:0] rval_reg;
    logic [DW-1:0]        idx_reg;        // entry whose data is being read
    logic                 rd_valid_reg;   // read data belongs to idx_reg-1
    logic [DW-1:0]        ridx_reg;
    logic                 found_reg;
    logic [IW-1:0]        slot_reg;
    logic [CW-1:0]        slot_count_reg;
    logic [CW-1:0]        match_reg;
    logic                 scan_done_reg;

    // divider
    logic [NUMW-1:0]      dnum_reg;
    logic [DIVW-1:0]      dden_reg;
    logic [DIVW:0]        drem_reg;
    logic [NBW-1:0]       dcnt_reg;
    logic                 div_done_reg;
    div_sel_t             dsel_reg;

    // multiplier for the variance terms
    logic [VW-1:0]        nsq_reg;        // n * sumsq
    logic [VW-1:0]        msq_reg;        // |sum|^2
    logic [SUMW-1:0]      mag_reg;
    logic [MSW-1:0]       mcnt_reg;
    logic                 mul_done_reg;

    // square root
    logic [VW-1:0]        sq_x_reg;
    logic [RW-1:0]        sq_res_reg;
    logic [$clog2(SQSTEPS+1)-1:0] sq_cnt_reg;
    logic                 sqrt_done_reg;

    logic [16:0]          prob_reg;
    logic signed [SW-1:0] mean_reg;
    logic [SW-1:0]        sigma_reg;
    logic [1:0]           status_reg;
    logic [CW-1:0]        out_match_reg;

    // -------- memory --------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            count_mem[wr_addr] <= wr_count;
        end
        rd_value <= value_mem[rd_addr];
        rd_count <= count_mem[rd_addr];
    end

    assign rd_addr = idx_reg[IW-1:0];

    // -------- scan --------
    logic hit;
    logic scan_end;
    always_comb
    begin
        if (rcmd_reg == CMD_CDF)
            hit = rd_value <= rval_reg;
        else
            hit = rd_value == rval_reg;
        scan_end = (ridx_reg >= distinct_reg);
    end

    logic full_reject;
    logic is_new;
    always_comb
    begin
        is_new = !found_reg;
        full_reject = (total_reg == {CW{1'b1}})
                    || (is_new && distinct_reg == DW'(TABLE_DEPTH));
        wr_en    = 1'b0;
        wr_addr  = slot_reg;
        wr_value = rval_reg;
        wr_count = slot_count_reg + 1'b1;
        if (cmd.op == OP_COMMIT && !full_reject)
        begin
            wr_en = 1'b1;
            if (is_new)
            begin
                wr_addr  = distinct_reg[IW-1:0];
                wr_count = CW'(1);
            end
        end
    end

    // -------- divider operands --------
    logic signed [SUMW-1:0] sum_s;
    logic                   sum_neg;
    logic [SUMW-1:0]        sum_mag;
    logic [CW-1:0]          n_m1;
    always_comb
    begin
        sum_s   = sum_reg;
        sum_neg = sum_s[SUMW-1];
        sum_mag = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
        n_m1    = total_reg - 1'b1;
    end

    // full-width square of the sample being added
    logic signed [2*SW-1:0] rval_sq;
    assign rval_sq = rval_reg * rval_reg;

    // one slice product a cycle
    logic [MULW-1:0]        nsq_slice, msq_slice;
    logic [CW+MULW-1:0]     nsq_pp;
    logic [SUMW+MULW-1:0]   msq_pp;
    always_comb
    begin
        nsq_slice = MULW'(sqsum_reg >> (mcnt_reg * MULW));
        msq_slice = MULW'(mag_reg >> (mcnt_reg * MULW));
        nsq_pp = total_reg * nsq_slice;
        msq_pp = mag_reg * msq_slice;
    end

    // divider step
    logic [DIVW:0]   drem_sh;
    logic            dge;
    always_comb
    begin
        drem_sh = {drem_reg[DIVW-1:0], dnum_reg[NUMW-1]};
        dge     = drem_sh >= {1'b0, dden_reg};
    end

    // root step: restoring, two bits at a time
    logic [VW-1:0]  sq_top;
    logic [RW+1:0]  sq_trial;
    logic [RW+1:0]  sq_rem_sh;
    logic [RW+1:0]  sq_rem_reg;
    always_comb
    begin
        sq_top    = sq_x_reg;
        sq_rem_sh = {sq_rem_reg[RW-1:0], sq_top[VW-1 -: 2]};
        sq_trial  = {sq_res_reg, 2'b01};
    end

    logic [VW-1:0] var_num;
    assign var_num = (nsq_reg >= msq_reg) ? nsq_reg - msq_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distinct_reg  <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            low_reg       <= SMAXV;
            high_reg      <= SMINV;
            scan_done_reg <= 1'b0;
            div_done_reg  <= 1'b0;
            mul_done_reg  <= 1'b0;
            sqrt_done_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            ridx_reg      <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LATCH:
                begin
                    rcmd_reg      <= in_command;
                    rval_reg      <= in_value;
                    idx_reg       <= '0;
                    ridx_reg      <= '0;
                    rd_valid_reg  <= 1'b0;
                    found_reg     <= 1'b0;
                    match_reg     <= '0;
                    scan_done_reg <= 1'b0;
                    prob_reg      <= '0;
                    mean_reg      <= '0;
                    sigma_reg     <= '0;
                    status_reg    <= STATUS_OK;
                    out_match_reg <= '0;
                end
                OP_SCAN:
                begin
                    // read issued at idx, data compared in the next cycle at ridx
                    if (!scan_done_reg)
                    begin
                        idx_reg      <= idx_reg + 1'b1;
                        rd_valid_reg <= 1'b1;
                        if (rd_valid_reg)
                        begin
                            if (scan_end)
                                scan_done_reg <= 1'b1;
                            else
                            begin
                                ridx_reg <= ridx_reg + 1'b1;
                                if (hit)
                                begin
                                    match_reg <= match_reg + rd_count;
                                    if (rcmd_reg == CMD_ADD)
                                    begin
                                        found_reg      <= 1'b1;
                                        slot_reg       <= ridx_reg[IW-1:0];
                                        slot_count_reg <= rd_count;
                                        scan_done_reg  <= 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_COMMIT:
                begin
                    if (full_reject)
                        status_reg <= STATUS_FULL;
                    else
                    begin
                        if (is_new)
                            distinct_reg <= distinct_reg + 1'b1;
                        total_reg <= total_reg + 1'b1;
                        sum_reg   <= sum_reg + SUMW'(rval_reg);
                        sqsum_reg <= sqsum_reg + SQW'($unsigned(rval_sq));
                        if (rval_reg < low_reg)
                            low_reg <= rval_reg;
                        if (rval_reg > high_reg)
                            high_reg <= rval_reg;
                    end
                end
                OP_CLEAR:
                begin
                    distinct_reg <= '0;
                    total_reg    <= '0;
                    sum_reg      <= '0;
                    sqsum_reg    <= '0;
                    low_reg      <= SMAXV;
                    high_reg     <= SMINV;
                end
                OP_DIV_INIT:
                begin
                    dsel_reg     <= cmd.div_sel;
                    drem_reg     <= '0;
                    dcnt_reg     <= NBW'(NUMW);
                    div_done_reg <= 1'b0;
                    case (cmd.div_sel)
                        DIV_PROB:
                        begin
                            out_match_reg <= match_reg;
                            dnum_reg <= NUMW'({match_reg, 16'd0});
                            dden_reg <= DIVW'(total_reg);
                        end
                        DIV_MEAN:
                        begin
                            dnum_reg <= NUMW'(sum_mag);
                            dden_reg <= DIVW'(total_reg);
                            mag_reg  <= sum_mag;
                            nsq_reg  <= '0;
                            msq_reg  <= '0;
                            mcnt_reg <= '0;
                            mul_done_reg <= 1'b0;
                        end
                        DIV_VAR:
                        begin
                            dnum_reg <= NUMW'(var_num);
                            if (population_mode)
                                dden_reg <= total_reg * total_reg;
                            else
                                dden_reg <= total_reg * n_m1;
                        end
                        default:
                        begin
                            dnum_reg <= '0;
                            dden_reg <= DIVW'(1);
                        end
                    endcase
                end
                OP_DIV_STEP:
                begin
                    if (!div_done_reg)
                    begin
                        drem_reg <= dge ? drem_sh - {1'b0, dden_reg} : drem_sh;
                        dnum_reg <= {dnum_reg[NUMW-2:0], dge};
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (dcnt_reg == NBW'(1))
                            div_done_reg <= 1'b1;
                    end
                    else
                    begin
                        case (dsel_reg)
                            DIV_PROB: prob_reg <= dnum_reg[16:0];
                            DIV_MEAN: mean_reg <= sum_neg ? SW'(~dnum_reg + 1'b1)
                                                          : SW'(dnum_reg);
                            default:  sq_x_reg <= VW'(dnum_reg);
                        endcase
                    end
                end
                OP_MUL_STEP:
                begin
                    if (mcnt_reg == MSW'(MSLICES))
                        mul_done_reg <= 1'b1;
                    else
                    begin
                        nsq_reg  <= nsq_reg + (VW'(nsq_pp) << (mcnt_reg * MULW));
                        msq_reg  <= msq_reg + (VW'(msq_pp) << (mcnt_reg * MULW));
                        mcnt_reg <= mcnt_reg + 1'b1;
                    end
                end
                OP_SQRT_INIT:
                begin
                    sq_res_reg    <= '0;
                    sq_rem_reg    <= '0;
                    sq_cnt_reg    <= '0;
                    sqrt_done_reg <= 1'b0;
                end
                OP_SQRT_STEP:
                begin
                    if (sq_cnt_reg == SQSTEPS[$bits(sq_cnt_reg)-1:0])
                    begin
                        sqrt_done_reg <= 1'b1;
                        sigma_reg <= (sq_res_reg > RW'({SW{1'b1}})) ? {SW{1'b1}}
                                                                     : SW'(sq_res_reg);
                    end
                    else
                    begin
                        sq_x_reg   <= sq_x_reg << 2;
                        sq_cnt_reg <= sq_cnt_reg + 1'b1;
                        if (sq_rem_sh >= sq_trial)
                        begin
                            sq_rem_reg <= sq_rem_sh - sq_trial;
                            sq_res_reg <= {sq_res_reg[RW-2:0], 1'b1};
                        end
                        else
                        begin
                            sq_rem_reg <= sq_rem_sh;
                            sq_res_reg <= {sq_res_reg[RW-2:0], 1'b0};
                        end
                    end
                end
                OP_RESULT:
                begin
                    if ((rcmd_reg == CMD_PDF || rcmd_reg == CMD_CDF
                         || rcmd_reg == CMD_SUMMARY) && stat.empty)
                        status_reg <= STATUS_UNDEFINED;
                    else if (rcmd_reg == CMD_SUMMARY && stat.too_few)
                        status_reg <= STATUS_UNDEFINED;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.scan_done = scan_done_reg;
    assign stat.div_done  = div_done_reg;
    assign stat.mul_done  = mul_done_reg;
    assign stat.sqrt_done = sqrt_done_reg;
    assign stat.empty     = (total_reg == '0);
    assign stat.too_few   = (total_reg == CW'(1)) && !population_mode;

    assign res_status   = status_reg;
    assign res_match    = out_match_reg;
    assign res_total    = total_reg;
    assign res_prob     = prob_reg;
    assign res_distinct = distinct_reg;
    assign res_lowest   = low_reg;
    assign res_highest  = high_reg;
    assign res_mean     = mean_reg;
    assign res_sigma    = sigma_reg;

    // match count never exceeds the total after a query scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV_INIT && cmd.div_sel == DIV_PROB) |-> match_reg <= total_reg)
        else $error("match count above total");
    assert property (@(posedge clk) disable iff (!rst_n)
        distinct_reg <= DW'(TABLE_DEPTH))
        else $error("distinct count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (distinct_reg == '0) |-> (total_reg == '0))
        else $error("samples held with empty table");
endmodule

### hw/rtl/shs_controller.sv
// ---------------------------------------------------------------------------
// shs_controller: request sequencer
// Steps each request through the scan, commit, divide, multiply and root phases that its command needs.
// ---------------------------------------------------------------------------
module shs_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           in_command,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 cfg_ready,
    output shs_pkg::dp_cmd_t     cmd,
    input  shs_pkg::dp_status_t  stat
);
    import shs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_SCAN     = 12'b000000000010,
        S_COMMIT   = 12'b000000000100,
        S_PDIV_I   = 12'b000000001000,
        S_PDIV     = 12'b000000010000,
        S_MDIV_I   = 12'b000000100000,
        S_MDIV     = 12'b000001000000,
        S_MUL      = 12'b000010000000,
        S_VDIV     = 12'b000100000000,
        S_SQRT     = 12'b001000000000,
        S_FINISH   = 12'b010000000000,
        S_OUT      = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] rcmd_reg;
    logic       vdiv_init_reg, vdiv_init_next;
    logic       sq_init_reg, sq_init_next;
    logic       done_wait_reg, done_wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rcmd_reg      <= '0;
            vdiv_init_reg <= 1'b0;
            sq_init_reg   <= 1'b0;
            done_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vdiv_init_reg <= vdiv_init_next;
            sq_init_reg   <= sq_init_next;
            done_wait_reg <= done_wait_next;
            if (state_reg == S_IDLE && in_valid)
                rcmd_reg <= in_command;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        vdiv_init_next = vdiv_init_reg;
        sq_init_next   = sq_init_reg;
        done_wait_next = 1'b0;
        cmd.op         = OP_NONE;
        cmd.div_sel    = DIV_PROB;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LATCH;
                    case (in_command)
                        CMD_ADD, CMD_PDF, CMD_CDF: state_next = S_SCAN;
                        CMD_SUMMARY:               state_next = S_MDIV_I;
                        CMD_CLEAR:                 state_next = S_FINISH;
                        default:                   state_next = S_FINISH;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_done)
                begin
                    cmd.op = OP_NONE;
                    if (rcmd_reg == CMD_ADD)
                        state_next = S_COMMIT;
                    else if (stat.empty)
                        state_next = S_FINISH;
                    else
                        state_next = S_PDIV_I;
                end
            end
            S_COMMIT:
            begin
                cmd.op = OP_COMMIT;
                state_next = S_FINISH;
            end
            S_PDIV_I:
            begin
                cmd.op = OP_DIV_INIT;
                cmd.div_sel = DIV_PROB;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                cmd.op = OP_DIV_STEP;
                // a further step after done stores the quotient
                if (stat.div_done)
                begin
                    if (done_wait_reg)
                    begin
                        cmd.op = OP_NONE;
                        state_next = S_FINISH;
                    end
                    else
                        done_wait_next = 1'b1;
                end
            end
            S_MDIV_I:
            begin
                if (stat.empty || stat.too_few)
                    state_next = S_FINISH;
                else
                begin
                    cmd.op = OP_DIV_INIT;
                    cmd.div_sel = DIV_MEAN;
                    state_next = S_MDIV;
                end
            end
            S_MDIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_done)
                begin
                    if (done_wait_reg)
                    begin
                        cmd.op = OP_NONE;
                        state_next = S_MUL;
                    end
                    else
                        done_wait_next = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                vdiv_init_next = 1'b1;
                if (stat.mul_done)
                begin
                    cmd.op = OP_NONE;
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                if (vdiv_init_reg)
                begin
                    cmd.op = OP_DIV_INIT;
                    cmd.div_sel = DIV_VAR;
                    vdiv_init_next = 1'b0;
                end
                else
                begin
                    cmd.op = OP_DIV_STEP;
                    sq_init_next = 1'b1;
                    if (stat.div_done)
                    begin
                        if (done_wait_reg)
                        begin
                            cmd.op = OP_NONE;
                            state_next = S_SQRT;
                        end
                        else
                            done_wait_next = 1'b1;
                    end
                end
            end
            S_SQRT:
            begin
                if (sq_init_reg)
                begin
                    cmd.op = OP_SQRT_INIT;
                    sq_init_next = 1'b0;
                end
                else
                begin
                    cmd.op = OP_SQRT_STEP;
                    if (stat.sqrt_done)
                    begin
                        cmd.op = OP_NONE;
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.op = (rcmd_reg == CMD_CLEAR) ? OP_CLEAR : OP_RESULT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign cfg_ready = (state_reg == S_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result shown in the cycle after accept");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
endmodule

### sim/sample_histogram_statistics_tb.sv
// ---------------------------------------------------------------------------
// sample_histogram_statistics_tb: self-checking bench for the histogram block
// Sends add, pdf, cdf, summary, clear and spare requests under random sender
// and receiver idling. A scoreboard predicts each result and checks it.
// ---------------------------------------------------------------------------
module sample_histogram_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shs_pkg::*;

    localparam int DEPTH = 256;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]         status;
        logic [23:0]        match_count;
        logic [23:0]        total_count;
        logic [16:0]        probability;
        logic [8:0]         distinct_count;
        logic signed [15:0] lowest;
        logic signed [15:0] highest;
        logic signed [15:0] mean;
        logic [15:0]        sigma;
    } hist_result_t;

    class hist_scoreboard;
        logic signed [15:0] values [DEPTH];
        logic [23:0]        counts [DEPTH];
        int                 distinct;
        logic [23:0]        total;
        logic signed [63:0] sum;
        logic [63:0]        square_sum;
        logic signed [15:0] low_seen;
        logic signed [15:0] high_seen;
        logic               population_mode;
        hist_result_t       awaited [$];
        int                 errors;
        int                 checked;
        int                 rejections;
        int                 undefined_seen;

        function new();
            population_mode = 1'b1;
            errors = 0;
            checked = 0;
            rejections = 0;
            undefined_seen = 0;
            empty_table();
        endfunction

        function void empty_table();
            distinct = 0;
            total = '0;
            sum = '0;
            square_sum = '0;
            low_seen = 16'sh7FFF;
            high_seen = -16'sh8000;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitv;
            res = '0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Predict the result of one accepted request.
        function void note(logic [2:0] cmd, logic signed [15:0] v);
            hist_result_t r;
            int           slot;
            logic [63:0]  match;
            logic [63:0]  mag;
            logic [63:0]  n;
            logic [127:0] lhs;
            logic [127:0] rhs;
            logic [127:0] divisor;
            logic [63:0]  variance;
            logic [63:0]  root;
            logic signed [63:0] avg;
            r = '0;
            match = '0;
            case (cmd)
                CMD_ADD:
                begin
                    slot = distinct;
                    for (int i = 0; i < distinct; i++)
                        if (values[i] == v)
                        begin
                            slot = i;
                            break;
                        end
                    if (total >= COUNT_MAX || slot >= DEPTH)
                    begin
                        r.status = STATUS_FULL;
                        rejections++;
                    end
                    else
                    begin
                        if (slot == distinct)
                        begin
                            values[slot] = v;
                            counts[slot] = 24'd1;
                            distinct++;
                        end
                        else
                            counts[slot]++;
                        total++;
                        sum = sum + 64'(v);
                        square_sum = square_sum + 64'(64'(v) * 64'(v));
                        if (v < low_seen)
                            low_seen = v;
                        if (v > high_seen)
                            high_seen = v;
                    end
                end
                CMD_PDF, CMD_CDF:
                begin
                    if (total == 0)
                        r.status = STATUS_UNDEFINED;
                    else
                    begin
                        for (int i = 0; i < distinct; i++)
                            if (cmd == CMD_PDF ? values[i] == v : values[i] <= v)
                                match = match + counts[i];
                        r.match_count = match[23:0];
                        r.probability = 17'((match << 16) / total);
                    end
                end
                CMD_SUMMARY:
                begin
                    n = 64'(total);
                    if (n == 0 || (!population_mode && n == 1))
                        r.status = STATUS_UNDEFINED;
                    else
                    begin
                        avg = sum / $signed(n);
                        r.mean = avg[15:0];
                        mag = sum[63] ? 64'(-sum) : 64'(sum);
                        lhs = 128'(n) * 128'(square_sum);
                        rhs = 128'(mag) * 128'(mag);
                        divisor = population_mode ? 128'(n * n) : 128'(n * (n - 1));
                        variance = (lhs < rhs) ? 64'd0 : 64'((lhs - rhs) / divisor);
                        root = floor_sqrt(variance);
                        r.sigma = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
                    end
                end
                CMD_CLEAR:
                    empty_table();
                default:
                    ;
            endcase
            if (r.status == STATUS_UNDEFINED)
                undefined_seen++;
            r.total_count = total;
            r.distinct_count = 9'(distinct);
            r.lowest = low_seen;
            r.highest = high_seen;
            awaited.push_back(r);
        endfunction

        function void check(hist_result_t act);
            hist_result_t exp_r;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with none pending: %p", $realtime, act);
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            checked++;
            if (act.status != exp_r.status)
                report("status", exp_r.status, act.status);
            if (act.match_count != exp_r.match_count)
                report("match_count", exp_r.match_count, act.match_count);
            if (act.total_count != exp_r.total_count)
                report("total_count", exp_r.total_count, act.total_count);
            if (act.probability != exp_r.probability)
                report("probability", exp_r.probability, act.probability);
            if (act.distinct_count != exp_r.distinct_count)
                report("distinct_count", exp_r.distinct_count, act.distinct_count);
            if (act.lowest != exp_r.lowest)
                report("lowest", exp_r.lowest, act.lowest);
            if (act.highest != exp_r.highest)
                report("highest", exp_r.highest, act.highest);
            if (act.mean != exp_r.mean)
                report("mean", exp_r.mean, act.mean);
            if (act.sigma != exp_r.sigma)
                report("sigma", exp_r.sigma, act.sigma);
        endfunction

        function void report(string field, logic signed [31:0] e, logic signed [31:0] a);
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, e, a);
            errors++;
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [2:0]          command = CMD_ADD;
    logic signed [15:0]  value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [23:0]         match_count;
    logic [23:0]         total_count;
    logic [16:0]         probability;
    logic [8:0]          distinct_count;
    logic signed [15:0]  lowest;
    logic signed [15:0]  highest;
    logic signed [15:0]  mean;
    logic [15:0]         sigma;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;

    int idle_in_pct  = 0;
    int idle_out_pct = 0;
    hist_scoreboard sb = new();

    sample_histogram_statistics i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .match_count    (match_count),
        .total_count    (total_count),
        .probability    (probability),
        .distinct_count (distinct_count),
        .lowest         (lowest),
        .highest        (highest),
        .mean           (mean),
        .sigma          (sigma),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check({status, match_count, total_count, probability, distinct_count,
                          lowest, highest, mean, sigma});
            out_stall <= ($urandom_range(99) < idle_out_pct);
        end
    end

    task automatic send(logic [2:0] cmd, logic signed [15:0] v);
        if ($urandom_range(99) < idle_in_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        value <= v;
        do
            @(posedge clk);
        while (in_stall);
        sb.note(cmd, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.population_mode = m;
    endtask

    function automatic logic signed [15:0] pick_value();
        // Mostly a small pool so values repeat; otherwise any 16-bit value.
        if ($urandom_range(99) < 70)
            return 16'($signed($urandom_range(0, 11)) - 6) * 16'sd97;
        return 16'($urandom);
    endfunction

    task automatic random_run(int items);
        int r;
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                send(CMD_ADD, pick_value());
            else if (r < 65)
                send(CMD_PDF, pick_value());
            else if (r < 80)
                send(CMD_CDF, pick_value());
            else if (r < 92)
                send(CMD_SUMMARY, pick_value());
            else if (r < 95)
                send(CMD_CLEAR, pick_value());
            else
                send(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), pick_value());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, then single sample in sample mode
        write_mode(1'b0);
        send(CMD_PDF, 16'sd0);
        send(CMD_CDF, 16'sh7FFF);
        send(CMD_SUMMARY, 16'sd0);
        send(CMD_ADD, -16'sh8000);
        send(CMD_SUMMARY, 16'sd0);
        send(CMD_ADD, 16'sh7FFF);
        send(CMD_ADD, 16'sh7FFF);
        send(CMD_ADD, 16'sd0);
        send(CMD_PDF, 16'sh7FFF);
        send(CMD_CDF, -16'sh8000);
        send(CMD_CDF, 16'sh7FFF);
        send(CMD_SUMMARY, 16'sd0);
        for (logic [3:0] c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send(c[2:0], 16'sh5555);
        write_mode(1'b1);
        send(CMD_SUMMARY, 16'shAAAA);
        send(CMD_CLEAR, 16'sd0);
        send(CMD_SUMMARY, 16'sd0);
        send(CMD_ADD, -16'sd5);
        send(CMD_SUMMARY, 16'sd0);

        // fill the table, then one new value (rejected) and one held value
        send(CMD_CLEAR, 16'sd0);
        for (int k = 0; k < DEPTH; k++)
            send(CMD_ADD, 16'(k * 255 - 32768));
        send(CMD_ADD, 16'sd1);
        send(CMD_ADD, -16'sh8000);
        send(CMD_PDF, -16'sh8000);
        send(CMD_CDF, 16'sd0);
        send(CMD_SUMMARY, 16'sd0);
        send(CMD_CLEAR, 16'sd0);

        idle_in_pct = 9;
        idle_out_pct = 55;
        random_run(240);
        write_mode(1'b0);
        idle_in_pct = 55;
        idle_out_pct = 9;
        random_run(240);
        write_mode(1'b1);
        idle_in_pct = 0;
        idle_out_pct = 0;
        random_run(240);

        drain();
        repeat (20) @(posedge clk);
        $display("Checked %0d results over both variance modes and three idling profiles;",
                 sb.checked);
        $display("%0d adds rejected as full, %0d undefined statistics.",
                 sb.rejections, sb.undefined_seen);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
